/* rtl/core/wlh_pkg.sv */
package wlh_pkg;

	localparam int MAX_WORD_LEN = 32;
	localparam int IDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int LEN_W = $clog2(MAX_WORD_LEN + 2);
	localparam int OCC_W = 24;
	localparam int WL_W = 6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WB,
		S_RD,
		S_CHK,
		S_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic idx_clr;
		logic idx_inc;
		logic rd_bin;
		logic load_bin;
		logic load_empty;
		logic clear_all;
	} wlh_cmd_t;

	typedef struct packed {
		logic no_words;
		logic bin_nonzero;
		logic bin_last;
		logic out_done;
		logic out_last;
	} wlh_status_t;

endpackage

/* rtl/core/wlh_ctrl.sv */
module wlh_ctrl import wlh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        req_type,
	output logic        in_ready,
	input  wlh_status_t status,
	output wlh_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   take;

	assign take = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take && req_type) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				if (status.no_words) begin
					state_d = S_OUT;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				if (status.bin_nonzero) begin
					state_d = S_OUT;
				end else begin
					state_d = S_RD;
				end
			end
			S_OUT: begin
				if (status.out_done) begin
					if (status.out_last) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = take;
			end
			S_WB: begin
				cmd.idx_clr = 1'b1;
				cmd.load_empty = status.no_words;
			end
			S_RD: begin
				cmd.rd_bin = 1'b1;
			end
			S_CHK: begin
				cmd.load_bin = status.bin_nonzero;
				cmd.idx_inc = ~status.bin_nonzero;
			end
			S_OUT: begin
				cmd.clear_all = status.out_done & status.out_last;
				cmd.idx_inc = status.out_done & ~status.out_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/core/wlh_datapath.sv */
module wlh_datapath import wlh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  wlh_cmd_t         cmd,
	input  logic             req_type,
	input  logic [7:0]       char_byte,
	output wlh_status_t      status,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WL_W-1:0]  bin_len,
	output logic [OCC_W-1:0] occurrences,
	output logic             last_bin,
	output logic             length_overflow
);

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD_LEN);
	localparam logic [OCC_W-1:0] OCC_MAX = '1;

	function automatic logic is_delim(input logic [7:0] c);
		is_delim = (c == 8'h20) || (c == 8'h2E) || (c == 8'h2C) || (c == 8'h3B) ||
			(c == 8'h28) || (c == 8'h29) || (c == 8'h0A);
	endfunction

	logic [OCC_W-1:0]        bins_mem [MAX_WORD_LEN];
	logic [MAX_WORD_LEN-1:0] bin_vld_q;
	logic [OCC_W-1:0]        rd_data_q;
	logic                    rd_vld_q;
	logic [LEN_W-1:0]        cur_len_q;
	logic [LEN_W-1:0]        longest_q;
	logic                    overflow_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    inc_s1;
	logic [IDX_W-1:0]        addr_s1;
	logic                    out_valid_q;
	logic [WL_W-1:0]         bin_len_q;
	logic [OCC_W-1:0]        occurrences_q;
	logic                    last_q;

	logic                    delim;
	logic                    close_now;
	logic [LEN_W-1:0]        close_len;
	logic [IDX_W-1:0]        close_addr;
	logic [IDX_W-1:0]        rd_addr;
	logic                    rd_en;
	logic [OCC_W-1:0]        bin_val;
	logic [OCC_W-1:0]        bin_next;
	logic [LEN_W-1:0]        idx_len;

	assign delim = is_delim(char_byte);
	assign close_now = cmd.take && (req_type || delim) && (cur_len_q != '0);
	assign close_len = (cur_len_q > MAX_LEN) ? MAX_LEN : cur_len_q;
	assign close_addr = IDX_W'(close_len - LEN_W'(1));
	assign rd_addr = close_now ? close_addr : idx_q;
	assign rd_en = close_now | cmd.rd_bin;
	assign bin_val = rd_vld_q ? rd_data_q : '0;
	assign bin_next = (bin_val == OCC_MAX) ? bin_val : bin_val + OCC_W'(1);
	assign idx_len = LEN_W'(idx_q) + LEN_W'(1);

	assign status.no_words = (longest_q == '0);
	assign status.bin_nonzero = (bin_val != '0);
	assign status.bin_last = (idx_len == longest_q);
	assign status.out_done = out_valid_q & out_ready;
	assign status.out_last = last_q;

	assign out_valid = out_valid_q;
	assign bin_len = bin_len_q;
	assign occurrences = occurrences_q;
	assign last_bin = last_q;
	assign length_overflow = overflow_q;

	// bin store: registered read; a word end writes back in the next cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= bins_mem[rd_addr];
		end
		if (inc_s1) begin
			bins_mem[addr_s1] <= bin_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			rd_vld_q <= 1'b0;
			inc_s1 <= 1'b0;
		end else begin
			inc_s1 <= close_now;
			if (rd_en) begin
				rd_vld_q <= bin_vld_q[rd_addr];
			end
			if (cmd.clear_all) begin
				bin_vld_q <= '0;
			end else if (inc_s1) begin
				bin_vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= close_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_len_q <= '0;
			longest_q <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.clear_all) begin
			cur_len_q <= '0;
			longest_q <= '0;
			overflow_q <= 1'b0;
		end else if (close_now) begin
			cur_len_q <= '0;
			if (close_len > longest_q) begin
				longest_q <= close_len;
			end
			if (cur_len_q > MAX_LEN) begin
				overflow_q <= 1'b1;
			end
		end else if (cmd.take && !req_type && !delim && (cur_len_q <= MAX_LEN)) begin
			cur_len_q <= cur_len_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q <= 1'b0;
		end else if (cmd.load_bin) begin
			out_valid_q <= 1'b1;
			last_q <= status.bin_last;
		end else if (cmd.load_empty) begin
			out_valid_q <= 1'b1;
			last_q <= 1'b1;
		end else if (status.out_done) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_bin) begin
			bin_len_q <= WL_W'(idx_len);
			occurrences_q <= bin_val;
		end else if (cmd.load_empty) begin
			bin_len_q <= '0;
			occurrences_q <= '0;
		end
	end

endmodule

/* rtl/core/word_length_histogram.sv */
// Word-length histogram. Text bytes (req_type 0) are taken one per cycle while idle;
// space, period, comma, semicolon, both parentheses and newline end a word, and each
// word end bumps a saturating 24-bit count for its length in a 32-entry bin memory (read
// at the word end, written back on the next cycle; two word ends are never adjacent).
// Words longer than MAX_WORD_LEN count in the top bin and raise length_overflow. An
// end request (req_type 1) closes any open word and stops input while the report runs:
// the single bin read port is walked from length 1 to the longest length seen; each bin
// is read and checked, each nonzero one held as one transaction until taken, last_bin on
// the final one. With no words a single marker of length 0, count 0 is sent. Taking the
// last transaction clears the histogram and input is accepted again on the next cycle.
module word_length_histogram import wlh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             req_type,
	input  logic [7:0]       char_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WL_W-1:0]  bin_len,
	output logic [OCC_W-1:0] occurrences,
	output logic             last_bin,
	output logic             length_overflow
);

	wlh_cmd_t    cmd;
	wlh_status_t status;

	wlh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	wlh_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.req_type        (req_type),
		.char_byte       (char_byte),
		.status          (status),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bin_len         (bin_len),
		.occurrences     (occurrences),
		.last_bin        (last_bin),
		.length_overflow (length_overflow)
	);

endmodule
